// File: hdl/oss_pkg.sv
// shared constants, types and a function for the ordered set successor unit
`default_nettype none

package oss_pkg;

    localparam int unsigned KEY_BITS_DEFAULT = 16;
    localparam int unsigned MODE_W = 2;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned LANE_W = 64;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOWER  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UPPER  = 2'd3;

    // enables for the two bitmap memories
    typedef struct packed {
        logic word_rd;
        logic word_wr;
        logic sum_rd;
        logic sum_wr;
    } oss_mem_ctl_t;

    // index of the lowest set bit, six halving steps
    function automatic logic [5:0] lowest_bit(input logic [LANE_W-1:0] x);
        logic [LANE_W-1:0] v;
        logic [5:0] n;
        v = x;
        n = '0;
        if (v[31:0] == 32'd0)
        begin
            n[5] = 1'b1;
            v = v >> 32;
        end
        if (v[15:0] == 16'd0)
        begin
            n[4] = 1'b1;
            v = v >> 16;
        end
        if (v[7:0] == 8'd0)
        begin
            n[3] = 1'b1;
            v = v >> 8;
        end
        if (v[3:0] == 4'd0)
        begin
            n[2] = 1'b1;
            v = v >> 4;
        end
        if (v[1:0] == 2'd0)
        begin
            n[1] = 1'b1;
            v = v >> 2;
        end
        if (v[0] == 1'b0)
        begin
            n[0] = 1'b1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: hdl/oss_ifs.sv
// request and response channel interfaces
`default_nettype none

interface oss_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] value;
    modport source (output valid, output mode, output value, input ready);
    modport sink (input valid, input mode, input value, output ready);
endinterface

interface oss_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] member;
    modport source (output valid, output found, output member, input ready);
    modport sink (input valid, input found, input member, output ready);
endinterface

`default_nettype wire

// File: hdl/oss_store.sv
// membership bitmap and summary bitmap memories, registered read
`default_nettype none

module oss_store #(
    parameter int unsigned KEY_BITS = oss_pkg::KEY_BITS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire oss_pkg::oss_mem_ctl_t ctl,
    input  wire logic [((KEY_BITS > 6) ? KEY_BITS - 6 : 1)-1:0] word_addr,
    input  wire logic [63:0]          word_wdata,
    output logic [63:0]               word_rdata,
    input  wire logic [((KEY_BITS > 12) ? KEY_BITS - 12 : 1)-1:0] sum_addr,
    input  wire logic [63:0]          sum_wdata,
    output logic [63:0]               sum_rdata
);
    import oss_pkg::*;

    localparam int unsigned WB = KEY_BITS - 6;
    localparam int unsigned SB = (WB > 6) ? WB - 6 : 0;
    localparam int unsigned WORD_COUNT = 1 << WB;
    localparam int unsigned SUM_COUNT = 1 << SB;

    logic [LANE_W-1:0] word_mem [WORD_COUNT];
    logic [LANE_W-1:0] sum_mem [SUM_COUNT];

    always_ff @(posedge clk)
    begin
        if (ctl.word_wr)
        begin
            word_mem[word_addr] <= word_wdata;
        end
        if (ctl.word_rd)
        begin
            word_rdata <= word_mem[word_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum_wr)
        begin
            sum_mem[sum_addr] <= sum_wdata;
        end
        if (ctl.sum_rd)
        begin
            sum_rdata <= sum_mem[sum_addr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/ordered_set_successor_unit.sv
// ordered key set with insert, remove, lower-bound and upper-bound queries
//
//  channel  dir  payload          moves
//  req      in   mode, value      one word per operation
//  rsp      out  found, member    one word per query, none for insert/remove
//
// insert and remove read both bitmaps, then write back; an out-of-range
// key changes nothing and is taken without either step
// a query answers from the threshold's own 64-key word, else from a later
// word of the same summary word, else by scanning further summary words
// (2^(KEY_BITS-12) - 1 at most)
// after reset a clearing pass over 2^(KEY_BITS-6) words (1024 by default)
// zeroes both memories while req.ready is low
// a result waits in the output register; a later query stalls at its last
// step until that register frees
`default_nettype none

module ordered_set_successor_unit #(
    parameter int unsigned KEY_BITS = oss_pkg::KEY_BITS_DEFAULT
) (
    input wire logic clk,
    input wire logic rst_n,
    oss_req_if.sink  req,
    oss_rsp_if.source rsp
);
    import oss_pkg::*;

    localparam int unsigned WB = KEY_BITS - 6;
    localparam int unsigned WIB = (WB > 0) ? WB : 1;
    localparam int unsigned SB = (WB > 6) ? WB - 6 : 0;
    localparam int unsigned SIB = (SB > 0) ? SB : 1;
    localparam int unsigned WORD_COUNT = 1 << WB;
    localparam int unsigned SUM_COUNT = 1 << SB;
    localparam logic [32:0] KEY_LIMIT = 33'(1) << KEY_BITS;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_UPDATE = 3'd2;
    localparam logic [2:0] ST_QWORD  = 3'd3;
    localparam logic [2:0] ST_QSCAN  = 3'd4;
    localparam logic [2:0] ST_QLAST  = 3'd5;

    logic [2:0]     state_reg, state_next;
    logic [WIB-1:0] clr_reg, clr_next;
    logic           ins_reg, ins_next;
    logic           miss_reg, miss_next;
    logic           last_word_reg, last_word_next;
    logic [5:0]     t_lo_reg, t_lo_next;
    logic [5:0]     s_lo_reg, s_lo_next;
    logic [WIB-1:0] w_reg, w_next;
    logic [SIB-1:0] sw_reg, sw_next;
    logic [WIB-1:0] wi_reg, wi_next;
    logic           rsp_valid_reg, rsp_valid_next;
    logic           found_reg, found_next;
    logic [15:0]    member_reg, member_next;

    oss_mem_ctl_t   ctl;
    logic [WIB-1:0] word_addr;
    logic [63:0]    word_wdata, word_rdata;
    logic [SIB-1:0] sum_addr;
    logic [63:0]    sum_wdata, sum_rdata;

    logic           acc;
    logic           slot_free;
    logic [31:0]    t32, acc_w32, acc_s32;
    logic           t_ok;
    logic [31:0]    clr32, w32, sw32, wi32_reg, swn32;
    logic [31:0]    key32, wi_full32, wi_scan32;
    logic [63:0]    bits, sbits, key_bit, sum_bit, new_word;
    logic [5:0]     pos_word, pos_sum, pos_scan, pos_last;
    logic           fin;
    logic           fin_found;
    logic [15:0]    fin_member;

    oss_store #(
        .KEY_BITS(KEY_BITS)
    ) u_store (
        .clk        (clk),
        .ctl        (ctl),
        .word_addr  (word_addr),
        .word_wdata (word_wdata),
        .word_rdata (word_rdata),
        .sum_addr   (sum_addr),
        .sum_wdata  (sum_wdata),
        .sum_rdata  (sum_rdata)
    );

    assign req.ready  = (state_reg == ST_IDLE);
    assign acc        = req.valid && req.ready;
    assign slot_free  = !rsp_valid_reg || rsp.ready;
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.found  = found_reg;
    assign rsp.member = member_reg;

    // threshold of an upper-bound query is value + 1
    assign t32     = {16'd0, req.value} + {31'd0, (req.mode == MODE_UPPER)};
    assign t_ok    = ({1'b0, t32} < KEY_LIMIT);
    assign acc_w32 = t32 >> 6;
    assign acc_s32 = acc_w32 + 32'd1;

    assign clr32    = {{(32 - WIB){1'b0}}, clr_reg};
    assign w32      = {{(32 - WIB){1'b0}}, w_reg};
    assign sw32     = {{(32 - SIB){1'b0}}, sw_reg};
    assign wi32_reg = {{(32 - WIB){1'b0}}, wi_reg};
    assign swn32    = sw32 + 32'd1;

    assign bits      = word_rdata & ({64{1'b1}} << t_lo_reg);
    assign sbits     = sum_rdata & ({64{1'b1}} << s_lo_reg);
    assign pos_word  = lowest_bit(bits);
    assign pos_sum   = lowest_bit(sbits);
    assign pos_scan  = lowest_bit(sum_rdata);
    assign pos_last  = lowest_bit(word_rdata);
    assign key32     = (w32 << 6) | {26'd0, pos_word};
    assign wi_full32 = (sw32 << 6) | {26'd0, pos_sum};
    assign wi_scan32 = (sw32 << 6) | {26'd0, pos_scan};

    assign key_bit  = 64'd1 << t_lo_reg;
    assign sum_bit  = 64'd1 << w32[5:0];
    assign new_word = ins_reg ? (word_rdata | key_bit) : (word_rdata & ~key_bit);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        ins_next       = ins_reg;
        miss_next      = miss_reg;
        last_word_next = last_word_reg;
        t_lo_next      = t_lo_reg;
        s_lo_next      = s_lo_reg;
        w_next         = w_reg;
        sw_next        = sw_reg;
        wi_next        = wi_reg;
        ctl            = '0;
        word_addr      = w_reg;
        word_wdata     = new_word;
        sum_addr       = sw_reg;
        sum_wdata      = sum_rdata;
        fin            = 1'b0;
        fin_found      = 1'b0;
        fin_member     = 16'd0;

        case (state_reg)
            ST_CLEAR:
            begin
                ctl.word_wr = 1'b1;
                ctl.sum_wr  = (clr32 < SUM_COUNT);
                word_addr   = clr_reg;
                word_wdata  = 64'd0;
                sum_addr    = clr32[SIB-1:0];
                sum_wdata   = 64'd0;
                clr_next    = WIB'(clr32 + 32'd1);
                if (clr32 == WORD_COUNT - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ins_next       = (req.mode == MODE_INSERT);
                miss_next      = !t_ok;
                t_lo_next      = t32[5:0];
                s_lo_next      = acc_s32[5:0];
                w_next         = acc_w32[WIB-1:0];
                last_word_next = (acc_w32 == WORD_COUNT - 1);
                word_addr      = acc_w32[WIB-1:0];
                if (req.mode == MODE_INSERT || req.mode == MODE_REMOVE)
                begin
                    sum_addr = acc_w32[6 +: SIB];
                    sw_next  = acc_w32[6 +: SIB];
                end
                else
                begin
                    sum_addr = acc_s32[6 +: SIB];
                    sw_next  = acc_s32[6 +: SIB];
                end
                if (acc)
                begin
                    if (req.mode == MODE_INSERT || req.mode == MODE_REMOVE)
                    begin
                        // out-of-range keys change nothing
                        if (t_ok)
                        begin
                            ctl.word_rd = 1'b1;
                            ctl.sum_rd  = 1'b1;
                            state_next  = ST_UPDATE;
                        end
                    end
                    else
                    begin
                        ctl.word_rd = t_ok;
                        ctl.sum_rd  = t_ok;
                        state_next  = ST_QWORD;
                    end
                end
            end
            ST_UPDATE:
            begin
                ctl.word_wr = 1'b1;
                ctl.sum_wr  = 1'b1;
                if (ins_reg)
                begin
                    sum_wdata = sum_rdata | sum_bit;
                end
                else if (new_word == 64'd0)
                begin
                    sum_wdata = sum_rdata & ~sum_bit;
                end
                state_next = ST_IDLE;
            end
            ST_QWORD:
            begin
                word_addr = wi_full32[WIB-1:0];
                sum_addr  = swn32[SIB-1:0];
                wi_next   = wi_full32[WIB-1:0];
                if (miss_reg)
                begin
                    fin = 1'b1;
                end
                else if (bits != 64'd0)
                begin
                    fin        = 1'b1;
                    fin_found  = 1'b1;
                    fin_member = key32[15:0];
                end
                else if (last_word_reg)
                begin
                    fin = 1'b1;
                end
                else if (sbits != 64'd0)
                begin
                    ctl.word_rd = 1'b1;
                    state_next  = ST_QLAST;
                end
                else if (sw32 == SUM_COUNT - 1)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    ctl.sum_rd = 1'b1;
                    sw_next    = swn32[SIB-1:0];
                    state_next = ST_QSCAN;
                end
                if (fin && slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_QSCAN:
            begin
                word_addr = wi_scan32[WIB-1:0];
                sum_addr  = swn32[SIB-1:0];
                wi_next   = wi_scan32[WIB-1:0];
                if (sum_rdata != 64'd0)
                begin
                    ctl.word_rd = 1'b1;
                    state_next  = ST_QLAST;
                end
                else if (sw32 == SUM_COUNT - 1)
                begin
                    fin = 1'b1;
                    if (slot_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    ctl.sum_rd = 1'b1;
                    sw_next    = swn32[SIB-1:0];
                end
            end
            ST_QLAST:
            begin
                fin        = 1'b1;
                fin_found  = 1'b1;
                fin_member = 16'((wi32_reg << 6) | {26'd0, pos_last});
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        found_next     = found_reg;
        member_next    = member_reg;
        if (fin && slot_free)
        begin
            rsp_valid_next = 1'b1;
            found_next     = fin_found;
            member_next    = fin_member;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_reg       <= ins_next;
        miss_reg      <= miss_next;
        last_word_reg <= last_word_next;
        t_lo_reg      <= t_lo_next;
        s_lo_reg      <= s_lo_next;
        w_reg         <= w_next;
        sw_reg        <= sw_next;
        wi_reg        <= wi_next;
        found_reg     <= found_next;
        member_reg    <= member_next;
    end

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !found_reg) |-> (member_reg == 16'd0))
        else $error("not-found word carries a nonzero member");

    a_update_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |=> (state_reg == ST_IDLE))
        else $error("write-back did not return to idle");

    a_member_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && found_reg) |-> ({17'd0, member_reg} < KEY_LIMIT))
        else $error("member outside key range");

    a_no_reclear: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> (state_reg != ST_CLEAR))
        else $error("clearing pass entered after an accepted word");
`endif

endmodule

`default_nettype wire
